@@ hw/rtl/deq_pkg.sv @@
package deq_pkg;

  // Request codes carried in the func field of an input word.
  localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FN_POP_FRONT  = 3'd2;
  localparam logic [2:0] FN_POP_BACK   = 3'd3;
  localparam logic [2:0] FN_CLEAR      = 3'd4;

  // Status codes returned with every result word.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } deq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load;
    logic        push_front;
    logic        push_back;
    logic        pop_front;
    logic        pop_back;
    logic        clear;
    deq_status_t status;
  } deq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } deq_stat_t;

endpackage

@@ hw/rtl/deq_in_if.sv @@
interface deq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] value_in;

  modport source (output valid, output func, output value_in, input ready);
  modport sink (input valid, input func, input value_in, output ready);
endinterface

@@ hw/rtl/deq_out_if.sv @@
interface deq_out_if #(
  parameter int CNT_W = 5
);
  logic             valid;
  logic             ready;
  logic [31:0]      value_out;
  logic [1:0]       status;
  logic [CNT_W-1:0] fill_count;
  logic             is_empty;

  modport source (output valid, output value_out, output status, output fill_count,
                  output is_empty, input ready);
  modport sink (input valid, input value_out, input status, input fill_count,
                input is_empty, output ready);
endinterface

@@ hw/rtl/deq_ctrl.sv @@
module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        func,
  output logic              out_valid,
  input  logic              out_ready,
  input  deq_pkg::deq_stat_t stat,
  output deq_pkg::deq_cmd_t  cmd
);

  deq_pkg::deq_state_t state_r;
  deq_pkg::deq_state_t state_nxt;
  logic                accept;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= deq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A new word is taken when idle, or when the held result leaves this cycle.
  always_comb begin
    in_ready  = (state_r == deq_pkg::S_IDLE) || out_ready;
    out_valid = (state_r == deq_pkg::S_RESP);
    accept    = in_valid && in_ready;
    state_nxt = state_r;
    unique case (state_r)
      deq_pkg::S_IDLE: begin
        if (accept) state_nxt = deq_pkg::S_RESP;
      end
      deq_pkg::S_RESP: begin
        if (accept) state_nxt = deq_pkg::S_RESP;
        else if (out_ready) state_nxt = deq_pkg::S_IDLE;
      end
      default: state_nxt = deq_pkg::S_IDLE;
    endcase
  end

  // Decode the request against the fill status of the queue.
  always_comb begin
    cmd            = '0;
    cmd.load       = accept;
    cmd.status     = deq_pkg::ST_OK;
    unique case (func)
      deq_pkg::FN_PUSH_FRONT: begin
        if (stat.full) cmd.status = deq_pkg::ST_FULL;
        else cmd.push_front = 1'b1;
      end
      deq_pkg::FN_PUSH_BACK: begin
        if (stat.full) cmd.status = deq_pkg::ST_FULL;
        else cmd.push_back = 1'b1;
      end
      deq_pkg::FN_POP_FRONT: begin
        if (stat.empty) cmd.status = deq_pkg::ST_EMPTY;
        else cmd.pop_front = 1'b1;
      end
      deq_pkg::FN_POP_BACK: begin
        if (stat.empty) cmd.status = deq_pkg::ST_EMPTY;
        else cmd.pop_back = 1'b1;
      end
      deq_pkg::FN_CLEAR: begin
        cmd.clear = 1'b1;
      end
      default: begin
        cmd.status = deq_pkg::ST_OK;
      end
    endcase
  end

endmodule

@@ hw/rtl/deq_datapath.sv @@
module deq_datapath #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  deq_pkg::deq_cmd_t  cmd,
  input  logic [31:0]        value_in,
  output deq_pkg::deq_stat_t stat,
  output logic [31:0]        value_out,
  output logic [1:0]         status,
  output logic [CNT_W-1:0]   fill_count,
  output logic               is_empty
);

  localparam int SUM_W = CNT_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  logic [31:0]         store_mem [DEPTH];
  logic [31:0]         rd_data_r;
  logic [IDX_W-1:0]    front_r;
  logic [IDX_W-1:0]    front_nxt;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  deq_pkg::deq_status_t status_r;
  logic                popped_r;
  logic [IDX_W-1:0]    prev_front;
  logic [IDX_W-1:0]    next_front;
  logic [SUM_W-1:0]    back_sum;
  logic [SUM_W-1:0]    last_sum;
  logic [IDX_W-1:0]    back_pos;
  logic [IDX_W-1:0]    last_pos;
  logic [IDX_W-1:0]    wr_addr;
  logic [IDX_W-1:0]    rd_addr;
  logic                do_write;
  logic                do_read;

  // Circular positions around the front pointer.
  always_comb begin
    prev_front = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
    next_front = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;
    back_sum   = SUM_W'(front_r) + SUM_W'(count_r);
    last_sum   = back_sum - 1'b1;
    back_pos   = (back_sum >= DEPTH_S) ? IDX_W'(back_sum - DEPTH_S) : IDX_W'(back_sum);
    last_pos   = (last_sum >= DEPTH_S) ? IDX_W'(last_sum - DEPTH_S) : IDX_W'(last_sum);
    wr_addr    = cmd.push_front ? prev_front : back_pos;
    rd_addr    = cmd.pop_front ? front_r : last_pos;
    do_write   = cmd.load && (cmd.push_front || cmd.push_back);
    do_read    = cmd.load && (cmd.pop_front || cmd.pop_back);
  end

  // Pointer and count update.
  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    if (cmd.load) begin
      if (cmd.clear) begin
        front_nxt = '0;
        count_nxt = '0;
      end else if (cmd.push_front) begin
        front_nxt = prev_front;
        count_nxt = count_r + 1'b1;
      end else if (cmd.push_back) begin
        count_nxt = count_r + 1'b1;
      end else if (cmd.pop_front) begin
        front_nxt = next_front;
        count_nxt = count_r - 1'b1;
      end else if (cmd.pop_back) begin
        count_nxt = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry store: at most one write or one registered read per request.
  always_ff @(posedge clk) begin
    if (do_write) store_mem[wr_addr] <= value_in;
    if (do_read) rd_data_r <= store_mem[rd_addr];
  end

  // Result fields held until the word is taken.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= cmd.status;
      popped_r <= cmd.pop_front || cmd.pop_back;
    end
  end

  assign stat.full  = (count_r == DEPTH_C);
  assign stat.empty = (count_r == '0);
  assign value_out  = popped_r ? rd_data_r : 32'd0;
  assign status     = status_r;
  assign fill_count = count_r;
  assign is_empty   = (count_r == '0);

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= LAST_IDX)
    else $error("front pointer out of range");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_read |=> (count_r + 1'b1) == $past(count_r))
    else $error("pop did not decrement count");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_write |=> count_r == ($past(count_r) + 1'b1))
    else $error("push did not increment count");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && cmd.clear) |=> (count_r == '0) && (front_r == '0))
    else $error("clear left entries");
`endif

endmodule

@@ hw/rtl/double_ended_queue_top.sv @@
// Bounded double-ended queue of signed 32-bit values in a circular store.
// Input channel in_if carries a request word: func (push front, push back,
// pop front, pop back, clear) and value_in. Output channel out_if returns one
// word per request: value_out (popped value, else zero), status (ok, empty on
// pop, full on push), fill_count and is_empty after the request.
// Both channels move a word on a clock edge with valid and ready high.
// Latency: the result is presented the cycle after the request is taken; the
// store is a single-port memory with a registered read, read in the accept
// cycle. Throughput: one request per cycle while results are taken at once.
// A new request is accepted in the same cycle the pending result is taken.
// When the receiver stalls, the result is held and in_if.ready stays low.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; store contents are not cleared and no sweep is needed.
// A pop on an empty queue or a push on a full one leaves the state unchanged.
module double_ended_queue_top #(
  parameter int DEPTH = 16
) (
  input logic          clk,
  input logic          rst_n,
  deq_in_if.sink       in_if,
  deq_out_if.source    out_if
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  deq_pkg::deq_cmd_t  cmd;
  deq_pkg::deq_stat_t stat;
  logic [CNT_W-1:0]   fill_count;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .func      (in_if.func),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  deq_datapath #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .value_in   (in_if.value_in),
    .stat       (stat),
    .value_out  (out_if.value_out),
    .status     (out_if.status),
    .fill_count (fill_count),
    .is_empty   (out_if.is_empty)
  );

  assign out_if.fill_count = fill_count;

endmodule

@@ dv/tb_double_ended_queue_top.sv @@
module tb_double_ended_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 16;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 1130;
  localparam int UNUSED_CODES = 3;
  localparam int LONG_HOLD    = 120;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 200_000;

  // One result word as the block reports it.
  typedef struct packed {
    logic [31:0]          value;
    deq_pkg::deq_status_t status;
    logic [CNT_W-1:0]     fill;
    logic                 empty;
  } deq_reply_t;

  // Shadow copy of the queue: predicts each result word and checks the
  // words that come back, oldest first.
  class deque_shadow;
    logic [31:0]      slots [DEPTH];
    logic [IDX_W-1:0] head = '0;
    logic [CNT_W-1:0] held = '0;
    deq_reply_t       pending_replies [$];
    int               mismatches = 0;
    int               replies_seen = 0;
    int               requests_seen = 0;
    int               empty_pops = 0;
    int               full_pushes = 0;
    int               clears = 0;
    int               unused_codes = 0;

    function void note_request(logic [2:0] fn, logic [31:0] word_in);
      deq_reply_t       r;
      logic [IDX_W-1:0] pos;
      r.value  = '0;
      r.status = deq_pkg::ST_OK;
      requests_seen++;
      case (fn)
        deq_pkg::FN_PUSH_FRONT, deq_pkg::FN_PUSH_BACK: begin
          if (held == DEPTH) begin
            r.status = deq_pkg::ST_FULL;
            full_pushes++;
          end else begin
            // A front push moves the head back one slot and writes there.
            if (fn == deq_pkg::FN_PUSH_FRONT) begin
              head = head - 1'b1;
              pos  = head;
            end else begin
              pos = head + held[IDX_W-1:0];
            end
            slots[pos] = word_in;
            held++;
          end
        end
        deq_pkg::FN_POP_FRONT, deq_pkg::FN_POP_BACK: begin
          if (held == 0) begin
            r.status = deq_pkg::ST_EMPTY;
            empty_pops++;
          end else begin
            if (fn == deq_pkg::FN_POP_FRONT) begin
              pos  = head;
              head = head + 1'b1;
            end else begin
              pos = head + held[IDX_W-1:0] - 1'b1;
            end
            r.value = slots[pos];
            held--;
          end
        end
        deq_pkg::FN_CLEAR: begin
          held = '0;
          head = '0;
          clears++;
        end
        default: begin
          unused_codes++;
        end
      endcase
      r.fill  = held;
      r.empty = (held == 0);
      pending_replies.push_back(r);
    endfunction

    function void check_reply(deq_reply_t got);
      deq_reply_t want;
      if (pending_replies.size() == 0) begin
        $error("Result word arrived with no request waiting for it.");
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      replies_seen++;
      if (got.value !== want.value) begin
        $error("value_out: expected %0d, got %0d", $signed(want.value), $signed(got.value));
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.fill !== want.fill) begin
        $error("fill_count: expected %0d, got %0d", want.fill, got.fill);
        mismatches++;
      end
      if (got.empty !== want.empty) begin
        $error("is_empty: expected %0d, got %0d", want.empty, got.empty);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   hold_request = 0;
  int   long_holds = 0;
  int   cycle_count = 0;

  deque_shadow shadow = new();

  deq_in_if                     in_if ();
  deq_out_if #(.CNT_W(CNT_W))   out_if ();

  double_ended_queue_top #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watch both channels at the rising edge. The request is noted before the
  // result is checked, so a word taken in the same cycle lands behind older ones.
  always @(posedge clk) begin : monitor
    deq_reply_t seen;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        shadow.note_request(in_if.func, in_if.value_in);
      end
      if (out_if.valid && out_if.ready) begin
        seen.value  = out_if.value_out;
        seen.status = deq_pkg::deq_status_t'(out_if.status);
        seen.fill   = out_if.fill_count;
        seen.empty  = out_if.is_empty;
        shadow.check_reply(seen);
      end
    end
  end

  // Receiver: switches between taking every word, stalling at random and a
  // periodic stall, and honors a request for one long hold-off.
  initial begin : receiver
    int mode;
    int mode_left;
    int period;
    int phase;
    int hold_len;
    mode      = 0;
    mode_left = 0;
    period    = 2;
    phase     = 0;
    out_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_len     = hold_request;
        hold_request = 0;
        out_if.ready = 1'b0;
        repeat (hold_len) @(negedge clk);
        long_holds++;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(32, 160);
        period    = $urandom_range(2, 6);
      end
      mode_left--;
      phase++;
      case (mode)
        0:       out_if.ready = 1'b1;
        1:       out_if.ready = ($urandom_range(0, 99) >= 35);
        default: out_if.ready = ((phase % period) != 0);
      endcase
    end
  end

  // Offers one request word and returns at the falling edge after it is taken.
  task automatic send_word(input logic [2:0] fn, input logic [31:0] word_in);
    in_if.valid    = 1'b1;
    in_if.func     = fn;
    in_if.value_in = word_in;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Leaves the input idle with scrambled payload for a number of cycles.
  task automatic idle_cycles(input int n);
    in_if.valid    = 1'b0;
    in_if.value_in = $urandom();
    repeat (n) @(negedge clk);
  endtask

  // Stops offering words until every predicted result has come back.
  task automatic wait_all_replies();
    in_if.valid = 1'b0;
    while (shadow.pending_replies.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int          random_sent;
    int          episode;
    int          ep_len;
    int          push_pct;
    int          burst_left;
    int          k;
    int          r;
    bit          no_gaps;
    logic [2:0]  fn;
    logic [31:0] word_in;

    in_if.valid    = 1'b0;
    in_if.func     = deq_pkg::FN_CLEAR;
    in_if.value_in = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Pops on an empty queue from both ends.
    send_word(deq_pkg::FN_POP_FRONT, 32'h1234_5678);
    send_word(deq_pkg::FN_POP_BACK, 32'h8765_4321);
    // Extreme values in and out at both ends.
    send_word(deq_pkg::FN_PUSH_FRONT, 32'h8000_0000);
    send_word(deq_pkg::FN_PUSH_BACK, 32'h7FFF_FFFF);
    send_word(deq_pkg::FN_POP_FRONT, '0);
    send_word(deq_pkg::FN_POP_BACK, '0);
    // Unused codes must leave the queue alone.
    for (k = 1; k <= UNUSED_CODES; k++) begin
      send_word(deq_pkg::FN_CLEAR + 3'(k), '1);
    end
    // Fill from both ends, then push on a full queue at both ends.
    for (k = 0; k < DEPTH; k++) begin
      word_in = (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF : (32'hA5A5_0000 | k);
      send_word(k[0] ? deq_pkg::FN_PUSH_BACK : deq_pkg::FN_PUSH_FRONT, word_in);
    end
    send_word(deq_pkg::FN_PUSH_BACK, 32'hDEAD_BEEF);
    send_word(deq_pkg::FN_PUSH_FRONT, 32'hBEEF_DEAD);
    send_word(deq_pkg::FN_CLEAR, '0);
    wait_all_replies();

    // Random episodes, each leaning toward filling, draining or a balance, so
    // the queue keeps reaching full and empty and wrapping around the store.
    random_sent = 0;
    episode     = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      ep_len  = $urandom_range(16, 64);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (episode % 9 == 4) begin
        // Long output stall while words keep coming, to back up the input.
        hold_request = LONG_HOLD;
        no_gaps      = 1'b1;
      end
      if (episode % 9 == 8) begin
        wait_all_replies();
      end
      burst_left = $urandom_range(1, 12);
      for (k = 0; k < ep_len && random_sent < RANDOM_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          fn = deq_pkg::FN_CLEAR;
        end else if (r < 5) begin
          fn = deq_pkg::FN_CLEAR + 3'($urandom_range(1, UNUSED_CODES));
        end else if ($urandom_range(0, 99) < push_pct) begin
          fn = $urandom_range(0, 1) ? deq_pkg::FN_PUSH_BACK : deq_pkg::FN_PUSH_FRONT;
        end else begin
          fn = $urandom_range(0, 1) ? deq_pkg::FN_POP_BACK : deq_pkg::FN_POP_FRONT;
        end
        case ($urandom_range(0, 15))
          0:       word_in = 32'h8000_0000;
          1:       word_in = 32'h7FFF_FFFF;
          2:       word_in = '1;
          3:       word_in = '0;
          default: word_in = $urandom();
        endcase
        send_word(fn, word_in);
        random_sent++;
        if (!no_gaps) begin
          burst_left--;
          if (burst_left == 0) begin
            idle_cycles($urandom_range(1, 6));
            burst_left = $urandom_range(1, 12);
          end
        end
      end
      episode++;
    end

    wait_all_replies();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (shadow.pending_replies.size() != 0) begin
      $error("%0d result words never arrived.", shadow.pending_replies.size());
    end
    $display("Covered %0d requests and %0d result words, including %0d pops when empty",
             shadow.requests_seen, shadow.replies_seen, shadow.empty_pops);
    $display("and %0d pushes when full, %0d clears, %0d unused codes, %0d long output stalls.",
             shadow.full_pushes, shadow.clears, shadow.unused_codes, long_holds);
    if (shadow.mismatches == 0 && shadow.pending_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Cycle counter that ends a hung run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles without finishing.", cycle_count);
    $display("Some tests failed");
    $finish;
  end

endmodule
